// File: rtl/brf_pkg.sv
package brf_pkg;

  // Ring geometry
  localparam int DEPTH   = 16;
  localparam int MAX_RUN = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int PTR_W   = IDX_W + 1;
  localparam int LEVEL_W = PTR_W;

  // Field widths of the channels
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int RLEN_W = 7;
  localparam int RUN_W  = $clog2(MAX_RUN + 1);
  localparam int CMP_W  = (RUN_W > LEVEL_W) ? RUN_W : LEVEL_W;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = Q_AW + 1;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DRAIN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd4;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_GET   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_DRAIN = 3'd3,
    OP_CLEAR = 3'd4,
    OP_BAD   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [BYTE_W-1:0] data_in;
    logic [RLEN_W-1:0] run_length;
  } cmd_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  data_out;
    logic               ok;
    logic               last;
    logic [LEVEL_W-1:0] level;
    logic               is_empty;
    logic               is_full;
  } res_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] data;
    logic [RUN_W-1:0]  run;
  } cls_item_t;

endpackage

// File: rtl/byte_ring_fifo_top.sv
// Channel   Direction  Handshake              Payload
// cmd       in         cmd_valid / cmd_stall  cmd_item (cmd, data_in, run_length)
// res       out        res_valid / res_stall  res_item (data_out, ok, last, level,
//                                             is_empty, is_full)
//
// Put, get, clear and unknown commands issue one per cycle while results are not
// stalled; a peek or drain run occupies the issue stage until its last byte is
// emitted, one store read per step, set by the single read port of the byte store.
// A command passes through the command queue, the store read stage and the output
// register before its first result is valid.
// Reset empties the ring and all pipeline stages; store contents are not cleared.
// A two-entry command queue keeps accepting while results are stalled; cmd_stall
// rises only when the queue is full.
module byte_ring_fifo_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  brf_pkg::cmd_item_t     cmd_item,
  output logic                   res_valid,
  input  logic                   res_stall,
  output brf_pkg::res_item_t     res_item
);

  logic                 head_valid;
  brf_pkg::cls_item_t   head;
  logic                 pop;

  brf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd_stall  (cmd_stall),
    .cmd_item   (cmd_item),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  brf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item)
  );

endmodule

// File: rtl/brf_ram.sv
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/brf_front.sv
module brf_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  brf_pkg::cmd_item_t     cmd_item,
  output logic                   head_valid,
  output brf_pkg::cls_item_t     head,
  input  logic                   pop
);

  brf_pkg::cls_item_t             q [brf_pkg::QUEUE_DEPTH];
  logic [brf_pkg::Q_AW-1:0]       wr_idx;
  logic [brf_pkg::Q_AW-1:0]       rd_idx;
  logic [brf_pkg::Q_CW-1:0]       count;
  logic                           push;
  brf_pkg::cls_item_t             cls;

  // Classify the command and saturate the run length
  always_comb begin
    cls.data = cmd_item.data_in;
    if (cmd_item.run_length > brf_pkg::RLEN_W'(brf_pkg::MAX_RUN)) begin
      cls.run = brf_pkg::RUN_W'(brf_pkg::MAX_RUN);
    end else begin
      cls.run = brf_pkg::RUN_W'(cmd_item.run_length);
    end
    case (cmd_item.cmd)
      brf_pkg::CMD_PUT:   cls.op = brf_pkg::OP_PUT;
      brf_pkg::CMD_GET:   cls.op = brf_pkg::OP_GET;
      brf_pkg::CMD_PEEK:  cls.op = brf_pkg::OP_PEEK;
      brf_pkg::CMD_DRAIN: cls.op = brf_pkg::OP_DRAIN;
      brf_pkg::CMD_CLEAR: cls.op = brf_pkg::OP_CLEAR;
      default:            cls.op = brf_pkg::OP_BAD;
    endcase
  end

  assign cmd_stall  = (count == brf_pkg::Q_CW'(brf_pkg::QUEUE_DEPTH));
  assign push       = cmd_valid && !cmd_stall;
  assign head_valid = (count != '0);
  assign head       = q[rd_idx];

  // Store classified transactions
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_idx] <= cls;
    end
  end

  // Advance queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_pop_needs_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty command queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= brf_pkg::Q_CW'(brf_pkg::QUEUE_DEPTH))
    else $error("command queue overfilled");

  a_stall_holds_count: assert property (@(posedge clk) disable iff (rst)
    cmd_stall && !pop |=> cmd_stall)
    else $error("full queue lost an entry without a pop");

endmodule

// File: rtl/brf_back.sv
module brf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   head_valid,
  input  brf_pkg::cls_item_t     head,
  output logic                   pop,
  output logic                   res_valid,
  input  logic                   res_stall,
  output brf_pkg::res_item_t     res_item
);

  brf_pkg::state_t                state;
  brf_pkg::state_t                state_next;
  logic [brf_pkg::PTR_W-1:0]      wp;
  logic [brf_pkg::PTR_W-1:0]      wp_next;
  logic [brf_pkg::PTR_W-1:0]      rp;
  logic [brf_pkg::PTR_W-1:0]      rp_next;
  logic [brf_pkg::PTR_W-1:0]      pos;
  logic [brf_pkg::PTR_W-1:0]      pos_next;
  logic [brf_pkg::RUN_W-1:0]      cnt;
  logic [brf_pkg::RUN_W-1:0]      cnt_next;
  logic                           drain_run;
  logic                           drain_run_next;

  logic [brf_pkg::LEVEL_W-1:0]    level_now;
  logic [brf_pkg::LEVEL_W-1:0]    level_res;
  logic [brf_pkg::CMP_W-1:0]      run_x;
  logic [brf_pkg::CMP_W-1:0]      lvl_x;
  logic [brf_pkg::RUN_W-1:0]      n;

  logic                           issue;
  logic                           r_ok;
  logic                           r_last;
  logic                           r_rd;
  logic                           we;
  logic [brf_pkg::IDX_W-1:0]      raddr;
  logic [brf_pkg::BYTE_W-1:0]     rdata;

  logic                           s1_valid;
  logic                           s1_rd;
  brf_pkg::res_item_t             s1_meta;
  brf_pkg::res_item_t             res_next;
  logic                           load_out;
  logic                           s1_free;

  // Pipeline flow: output register, then read stage, then issue
  assign load_out = !res_valid || !res_stall;
  assign s1_free  = !s1_valid || load_out;
  assign issue    = s1_free && ((state == brf_pkg::ST_RUN) || head_valid);
  assign pop      = s1_free && (state == brf_pkg::ST_IDLE) && head_valid;

  // Clip the run to the fill level
  assign level_now = brf_pkg::LEVEL_W'(wp - rp);
  assign run_x     = brf_pkg::CMP_W'(head.run);
  assign lvl_x     = brf_pkg::CMP_W'(level_now);
  assign n         = (run_x < lvl_x) ? brf_pkg::RUN_W'(run_x) : brf_pkg::RUN_W'(lvl_x);

  // Execute one step of the current command
  always_comb begin
    state_next     = state;
    wp_next        = wp;
    rp_next        = rp;
    pos_next       = pos;
    cnt_next       = cnt;
    drain_run_next = drain_run;
    r_ok           = 1'b0;
    r_last         = 1'b1;
    r_rd           = 1'b0;
    we             = 1'b0;
    raddr          = rp[brf_pkg::IDX_W-1:0];
    case (state)
      brf_pkg::ST_RUN: begin
        raddr    = pos[brf_pkg::IDX_W-1:0];
        r_rd     = 1'b1;
        r_ok     = 1'b1;
        r_last   = (cnt == brf_pkg::RUN_W'(1));
        pos_next = pos + 1'b1;
        cnt_next = cnt - 1'b1;
        if (drain_run) begin
          rp_next = pos + 1'b1;
        end
        if (cnt == brf_pkg::RUN_W'(1)) begin
          state_next = brf_pkg::ST_IDLE;
        end
      end
      brf_pkg::ST_IDLE: begin
        case (head.op)
          brf_pkg::OP_PUT: begin
            if (level_now != brf_pkg::LEVEL_W'(brf_pkg::DEPTH)) begin
              we      = 1'b1;
              wp_next = wp + 1'b1;
              r_ok    = 1'b1;
            end
          end
          brf_pkg::OP_GET: begin
            if (level_now != '0) begin
              r_rd    = 1'b1;
              r_ok    = 1'b1;
              rp_next = rp + 1'b1;
            end
          end
          brf_pkg::OP_PEEK, brf_pkg::OP_DRAIN: begin
            if (n != '0) begin
              r_rd           = 1'b1;
              r_ok           = 1'b1;
              r_last         = (n == brf_pkg::RUN_W'(1));
              pos_next       = rp + 1'b1;
              cnt_next       = n - 1'b1;
              drain_run_next = (head.op == brf_pkg::OP_DRAIN);
              if (head.op == brf_pkg::OP_DRAIN) begin
                rp_next = rp + 1'b1;
              end
              if (n != brf_pkg::RUN_W'(1)) begin
                state_next = brf_pkg::ST_RUN;
              end
            end
          end
          brf_pkg::OP_CLEAR: begin
            wp_next = '0;
            rp_next = '0;
            r_ok    = 1'b1;
          end
          default: begin
            r_ok = 1'b0;
          end
        endcase
      end
      default: begin
        state_next = brf_pkg::ST_IDLE;
      end
    endcase
  end

  assign level_res = brf_pkg::LEVEL_W'(wp_next - rp_next);

  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (brf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (issue && we),
    .waddr (wp[brf_pkg::IDX_W-1:0]),
    .wdata (head.data),
    .re    (issue && r_rd),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Update ring and run state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= brf_pkg::ST_IDLE;
      wp        <= '0;
      rp        <= '0;
      pos       <= '0;
      cnt       <= '0;
      drain_run <= 1'b0;
    end else if (issue) begin
      state     <= state_next;
      wp        <= wp_next;
      rp        <= rp_next;
      pos       <= pos_next;
      cnt       <= cnt_next;
      drain_run <= drain_run_next;
    end
  end

  // Read stage: hold result fields while the store read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && issue) begin
      s1_rd             <= r_rd;
      s1_meta.data_out  <= '0;
      s1_meta.ok        <= r_ok;
      s1_meta.last      <= r_last;
      s1_meta.level     <= level_res;
      s1_meta.is_empty  <= (level_res == '0);
      s1_meta.is_full   <= (level_res == brf_pkg::LEVEL_W'(brf_pkg::DEPTH));
    end
  end

  // Merge the store byte into the result fields
  always_comb begin
    res_next          = s1_meta;
    res_next.data_out = s1_rd ? rdata : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && s1_valid) begin
      res_item <= res_next;
    end
  end

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level_now <= brf_pkg::LEVEL_W'(brf_pkg::DEPTH))
    else $error("fill level above depth");

  a_run_count: assert property (@(posedge clk) disable iff (rst)
    state == brf_pkg::ST_RUN |-> cnt != '0)
    else $error("run state with no bytes left");

  a_run_reads: assert property (@(posedge clk) disable iff (rst)
    state == brf_pkg::ST_RUN && s1_free |=> s1_valid && s1_rd)
    else $error("run step did not issue a store read");

  a_no_pop_in_run: assert property (@(posedge clk) disable iff (rst)
    state == brf_pkg::ST_RUN |-> !pop)
    else $error("command popped during a run");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !load_out |=> s1_valid && $stable(s1_meta))
    else $error("read stage lost a result under stall");

endmodule

// File: verif/byte_ring_fifo_top_test.sv
module byte_ring_fifo_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  // Highest unassigned command code; codes above CMD_CLEAR leave the ring unchanged and return ok low
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 320;

  // One directed entry: repeated count times, data_in bumped on each repeat
  typedef struct {
    cmd_item_t item;
    int        count;
    bit        typed;
    res_item_t want;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cmd_valid = 1'b0;
  logic      cmd_stall;
  cmd_item_t cmd_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  // Ring image used to predict results
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr = '0;
  logic [PTR_W-1:0]  rd_ptr = '0;

  res_item_t ring_res_q [$];
  plan_row_t plan_q [$];
  int        mismatches = 0;
  int        stall_left = 0;

  byte_ring_fifo_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  always #5 clk = ~clk;

  // Queue one predicted result using the current fill level
  function automatic void ring_emit(input logic [BYTE_W-1:0] d, input logic ok,
                                    input logic last);
    res_item_t          r;
    logic [LEVEL_W-1:0] lvl;
    lvl = wr_ptr - rd_ptr;
    r.data_out = d;
    r.ok       = ok;
    r.last     = last;
    r.level    = lvl;
    r.is_empty = (lvl == 0);
    r.is_full  = (lvl == DEPTH);
    ring_res_q.push_back(r);
  endfunction

  // Advance the ring image by one command and queue its results
  function automatic void ring_apply(input cmd_item_t c);
    logic [LEVEL_W-1:0] lvl;
    logic [PTR_W-1:0]   pos;
    logic [BYTE_W-1:0]  d;
    int unsigned        n;
    lvl = wr_ptr - rd_ptr;
    case (c.cmd)
      CMD_PUT: begin
        if (lvl < DEPTH) begin
          ring_mem[wr_ptr[IDX_W-1:0]] = c.data_in;
          wr_ptr = wr_ptr + 1'b1;
          ring_emit('0, 1'b1, 1'b1);
        end else begin
          ring_emit('0, 1'b0, 1'b1);
        end
      end
      CMD_GET: begin
        if (lvl != 0) begin
          d = ring_mem[rd_ptr[IDX_W-1:0]];
          rd_ptr = rd_ptr + 1'b1;
          ring_emit(d, 1'b1, 1'b1);
        end else begin
          ring_emit('0, 1'b0, 1'b1);
        end
      end
      CMD_PEEK, CMD_DRAIN: begin
        // Clip the run to MAX_RUN and to what the ring holds
        n = 32'(c.run_length);
        if (n > MAX_RUN) n = MAX_RUN;
        if (n > lvl) n = 32'(lvl);
        if (n == 0) begin
          ring_emit('0, 1'b0, 1'b1);
        end else begin
          pos = rd_ptr;
          for (int i = 0; i < n; i++) begin
            d = ring_mem[pos[IDX_W-1:0]];
            pos = pos + 1'b1;
            if (c.cmd == CMD_DRAIN) rd_ptr = pos;
            ring_emit(d, 1'b1, i == n - 1);
          end
        end
      end
      CMD_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        ring_emit('0, 1'b1, 1'b1);
      end
      default: begin
        ring_emit('0, 1'b0, 1'b1);
      end
    endcase
  endfunction

  function automatic res_item_t res_of(input logic [BYTE_W-1:0] d, input logic ok,
                                       input logic last, input logic [LEVEL_W-1:0] lvl,
                                       input logic is_empty, input logic is_full);
    res_item_t r;
    r.data_out = d;
    r.ok       = ok;
    r.last     = last;
    r.level    = lvl;
    r.is_empty = is_empty;
    r.is_full  = is_full;
    return r;
  endfunction

  function automatic void plan(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] d,
                               input logic [RLEN_W-1:0] rlen, input int count,
                               input bit typed, input res_item_t want);
    plan_row_t row;
    row.item.cmd        = cmd;
    row.item.data_in    = d;
    row.item.run_length = rlen;
    row.count           = count;
    row.typed           = typed;
    row.want            = want;
    plan_q.push_back(row);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random command; fill phases lean toward puts, emptying phases toward reads
  function automatic cmd_item_t pick_cmd(input bit fill_phase);
    cmd_item_t c;
    int        r;
    int        put_pct;
    put_pct = fill_phase ? 55 : 20;
    r = $urandom_range(0, 99);
    if (r < put_pct) c.cmd = CMD_PUT;
    else if (r < put_pct + (100 - put_pct) * 35 / 100) c.cmd = CMD_GET;
    else if (r < put_pct + (100 - put_pct) * 60 / 100) c.cmd = CMD_PEEK;
    else if (r < 93) c.cmd = CMD_DRAIN;
    else if (r < 97) c.cmd = CMD_CLEAR;
    else c.cmd = CMD_W'($urandom_range(int'(CMD_CLEAR) + 1, int'(CMD_UNUSED)));
    c.data_in = BYTE_W'($urandom_range(0, 255));
    r = $urandom_range(0, 99);
    if (r < 70) c.run_length = RLEN_W'($urandom_range(0, 20));
    else if (r < 90) c.run_length = RLEN_W'($urandom_range(0, MAX_RUN));
    else c.run_length = RLEN_W'($urandom_range(0, 127));
    return c;
  endfunction

  // Present one command after a gap and hold it until accepted
  task automatic send_cmd(input cmd_item_t c, input int gap);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Result stall: free stretches, short stalls, and the odd long one
  always @(posedge clk) begin : res_stall_gen
    int r;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 9);
      if (r < 4) begin
        res_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 30);
      end else if (r < 9) begin
        res_stall  <= (r < 7) ? 1'b0 : 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        res_stall  <= 1'b1;
        stall_left <= $urandom_range(8, 40);
      end
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin : res_check
    res_item_t want;
    if (!rst && res_valid === 1'b1 && res_stall == 1'b0) begin
      if (ring_res_q.size() == 0) begin
        $display("%0t ns: unexpected result, got 0x%0h", $time, res_item);
        mismatches++;
      end else begin
        want = ring_res_q.pop_front();
        check_field("data_out", want.data_out, res_item.data_out);
        check_field("ok", want.ok, res_item.ok);
        check_field("last", want.last, res_item.last);
        check_field("level", want.level, res_item.level);
        check_field("is_empty", want.is_empty, res_item.is_empty);
        check_field("is_full", want.is_full, res_item.is_full);
      end
    end
  end

  initial begin
    #10ms;
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    cmd_item_t c;
    // Empty ring: reads and runs come back invalid, then two puts
    plan(CMD_GET, 8'h00, 7'd0, 1, 1'b1, res_of(8'h00, 1'b0, 1'b1, 5'd0, 1'b1, 1'b0));
    plan(CMD_DRAIN, 8'h00, 7'd5, 1, 1'b1, res_of(8'h00, 1'b0, 1'b1, 5'd0, 1'b1, 1'b0));
    plan(CMD_PUT, 8'h00, 7'd0, 1, 1'b1, res_of(8'h00, 1'b1, 1'b1, 5'd1, 1'b0, 1'b0));
    plan(CMD_PUT, 8'hFF, 7'd127, 1, 1'b1, res_of(8'h00, 1'b1, 1'b1, 5'd2, 1'b0, 1'b0));
    // Zero-length run, then a run_length that saturates, then a drain of one byte
    plan(CMD_PEEK, 8'h00, 7'd0, 1, 1'b1, res_of(8'h00, 1'b0, 1'b1, 5'd2, 1'b0, 1'b0));
    plan(CMD_PEEK, 8'h00, 7'd127, 1, 1'b0, '0);
    plan(CMD_DRAIN, 8'h00, 7'd1, 1, 1'b0, '0);
    // Fill to DEPTH, then overflow and an unassigned command on a full ring
    plan(CMD_PUT, 8'hA5, 7'd0, DEPTH - 2, 1'b0, '0);
    plan(CMD_PUT, 8'h5A, 7'd0, 1, 1'b1, res_of(8'h00, 1'b1, 1'b1, 5'd16, 1'b0, 1'b1));
    plan(CMD_PUT, 8'h77, 7'd0, 1, 1'b1, res_of(8'h00, 1'b0, 1'b1, 5'd16, 1'b0, 1'b1));
    plan(CMD_UNUSED, 8'hFF, 7'd127, 1, 1'b1,
         res_of(8'h00, 1'b0, 1'b1, 5'd16, 1'b0, 1'b1));
    // Drain everything in one run, then clear a nonempty ring
    plan(CMD_DRAIN, 8'h00, 7'd64, 1, 1'b0, '0);
    plan(CMD_PUT, 8'h3C, 7'd0, 1, 1'b0, '0);
    plan(CMD_CLEAR, 8'h00, 7'd0, 1, 1'b1, res_of(8'h00, 1'b1, 1'b1, 5'd0, 1'b1, 1'b0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (plan_q[i]) begin
      for (int k = 0; k < plan_q[i].count; k++) begin
        c = plan_q[i].item;
        c.data_in = c.data_in + BYTE_W'(k);
        send_cmd(c, pick_gap());
        ring_apply(c);
        if (plan_q[i].typed) begin
          void'(ring_res_q.pop_back());
          ring_res_q.push_back(plan_q[i].want);
        end
      end
    end

    // Random traffic in alternating fill and emptying phases
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      c = pick_cmd(((i / 40) % 2) == 0);
      send_cmd(c, pick_gap());
      ring_apply(c);
    end
    cmd_valid <= 1'b0;

    while (ring_res_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/brf_front.sv
rtl/brf_back.sv
rtl/byte_ring_fifo_top.sv
verif/byte_ring_fifo_top_test.sv
